// ===== src/bnm_pkg.sv =====
// ============================================================================
// Bracket nesting matcher package
// Shared constants, codes and types of the bracket nesting matcher.
// ============================================================================
package bnm_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int INDEX_BITS  = 24;
  localparam int POS_BITS    = 32;
  localparam int DEPTH_W     = 7;
  localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

  // token classes
  localparam logic [2:0] TOK_OTHER     = 3'd0;
  localparam logic [2:0] TOK_OPEN_BRC  = 3'd3;
  localparam logic [2:0] TOK_CLOSE_PAR = 3'd4;
  localparam logic [2:0] TOK_CLOSE_BRC = 3'd6;
  localparam logic [2:0] TOK_END       = 3'd7;

  // node kinds
  localparam logic [2:0] NODE_NIL   = 3'd0;
  localparam logic [2:0] NODE_PLAIN = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DANGLE_LO = 3'd4;
  localparam logic [2:0] ST_DANGLE_HI = 3'd6;
  localparam logic [2:0] ST_OVERFLOW  = 3'd7;

  // offset between a closer (or dangling) code and its bracket kind
  localparam logic [2:0] KIND_OFFSET = 3'd3;

  typedef enum logic {
    S_RUN,
    S_DRAIN
  } bnm_state_e;

  typedef struct packed {
    logic [1:0]            kind;
    logic [INDEX_BITS-1:0] idx;
    logic [POS_BITS-1:0]   pos;
  } bnm_entry_t;

  localparam int ENTRY_W = $bits(bnm_entry_t);

endpackage

// ===== src/bnm_ram.sv =====
// ============================================================================
// Bracket nesting matcher RAM
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module bnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bracket_nesting_matcher_core.sv =====
// ============================================================================
// Bracket nesting matcher core
// Matches classified bracket tokens against a stack of open brackets.
// ============================================================================
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one token request: its
//   class and source position. Output channel (out_valid_o / out_stall_i)
//   carries result requests. A request moves when valid is high and stall
//   is low.
//   Each token but the end marker gives one result, registered: it appears
//   the cycle after the token is taken. Plain tokens, openers and closers
//   sustain one token per cycle while the receiver does not stall; the top
//   of stack lives in flops and the stack RAM refill after a pop is forwarded
//   from its read port, so pops back to back do not stall.
//   The end marker drains the stack: one dangling-opener result per open
//   entry, one per cycle unless the receiver stalls, paced by the RAM read
//   port; with more than one open entry the input stalls until the drain ends.
//   Results of one end marker carry last on the final one only.
//   When the receiver stalls, the output register holds and the input stalls
//   as soon as the pending result cannot be replaced.
//   Reset clears the depth, the token counter and the control flags; stack
//   contents are left as they are and are never read before being written.
// ============================================================================
module bracket_nesting_matcher_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    token_class_i,
  input  logic [bnm_pkg::POS_BITS-1:0]  token_pos_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bnm_pkg::INDEX_BITS-1:0] token_index_o,
  output logic [2:0]                    node_kind_o,
  output logic [bnm_pkg::INDEX_BITS-1:0] match_index_o,
  output logic [2:0]                    status_o,
  output logic [bnm_pkg::POS_BITS-1:0]  err_pos_start_o,
  output logic [bnm_pkg::POS_BITS-1:0]  err_pos_end_o,
  output logic [bnm_pkg::DEPTH_W-1:0]   nest_depth_o,
  output logic                          last_o
);

  import bnm_pkg::*;

  // control state
  bnm_state_e            state_q, state_d;
  logic [DEPTH_W-1:0]    depth_q, depth_d;
  logic [INDEX_BITS-1:0] count_q, count_d;
  logic                  fill_q, fill_d;   // top_q is stale, RAM read data is the top
  // top of stack and drain token index
  bnm_entry_t            top_q, top_d;
  logic [INDEX_BITS-1:0] drain_idx_q, drain_idx_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [INDEX_BITS-1:0] o_idx_q, o_idx_d;
  logic [2:0]            o_kind_q, o_kind_d;
  logic [INDEX_BITS-1:0] o_match_q, o_match_d;
  logic [2:0]            o_status_q, o_status_d;
  logic [POS_BITS-1:0]   o_ps_q, o_ps_d;
  logic [POS_BITS-1:0]   o_pe_q, o_pe_d;
  logic [DEPTH_W-1:0]    o_depth_q, o_depth_d;
  logic                  o_last_q, o_last_d;

  // RAM holds every entry below the top one
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  bnm_entry_t            ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0]    ram_rdata_raw;

  logic                  out_free, in_take;
  bnm_entry_t            top_eff;
  logic [1:0]            want_kind;

  bnm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = bnm_entry_t'(ram_rdata_raw);
  assign top_eff   = fill_q ? ram_rdata : top_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_RUN) || !out_free;
  assign in_take   = in_valid_i && !in_stall_o;
  assign want_kind = 2'(token_class_i - KIND_OFFSET);

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    count_d     = count_q;
    fill_d      = 1'b0;
    top_d       = top_eff;
    drain_idx_d = drain_idx_q;

    ram_we    = 1'b0;
    ram_waddr = ADDR_W'(depth_q - DEPTH_W'(1));
    ram_wdata = top_eff;
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(depth_q - DEPTH_W'(2));

    out_valid_d = out_valid_q && out_stall_i;
    o_idx_d     = o_idx_q;
    o_kind_d    = o_kind_q;
    o_match_d   = o_match_q;
    o_status_d  = o_status_q;
    o_ps_d      = o_ps_q;
    o_pe_d      = o_pe_q;
    o_depth_d   = o_depth_q;
    o_last_d    = o_last_q;

    case (state_q)
      S_RUN: begin
        if (in_take) begin
          out_valid_d = 1'b1;
          o_idx_d     = count_q;
          o_kind_d    = NODE_NIL;
          o_match_d   = '0;
          o_status_d  = ST_OK;
          o_ps_d      = '0;
          o_pe_d      = '0;
          o_last_d    = 1'b1;
          count_d     = count_q + INDEX_BITS'(1);
          o_depth_d   = depth_q;

          if (token_class_i == TOK_OTHER) begin
            o_kind_d = NODE_PLAIN;
          end else if (token_class_i <= TOK_OPEN_BRC) begin
            o_kind_d = token_class_i;
            if (depth_q < DEPTH_W'(STACK_DEPTH)) begin
              // old top sinks into the RAM, new opener becomes the top
              ram_we     = (depth_q != '0);
              top_d.kind = token_class_i[1:0];
              top_d.idx  = count_q;
              top_d.pos  = token_pos_i;
              depth_d    = depth_q + DEPTH_W'(1);
              o_depth_d  = depth_q + DEPTH_W'(1);
            end else begin
              o_status_d = ST_OVERFLOW;
              o_ps_d     = token_pos_i;
              o_pe_d     = token_pos_i;
            end
          end else if (token_class_i <= TOK_CLOSE_BRC) begin
            if (depth_q != '0 && top_eff.kind == want_kind) begin
              o_match_d = top_eff.idx;
              depth_d   = depth_q - DEPTH_W'(1);
              o_depth_d = depth_q - DEPTH_W'(1);
              if (depth_q > DEPTH_W'(1)) begin
                ram_re = 1'b1;
                fill_d = 1'b1;
              end
            end else begin
              o_status_d = {1'b0, want_kind};
              o_ps_d     = (depth_q != '0) ? top_eff.pos : '0;
              o_pe_d     = token_pos_i;
            end
          end else begin
            // end marker: report the top, then drain the rest from RAM
            count_d     = '0;
            drain_idx_d = count_q;
            if (depth_q != '0) begin
              o_match_d  = top_eff.idx;
              o_status_d = {1'b0, top_eff.kind} + KIND_OFFSET;
              o_ps_d     = top_eff.pos;
              o_pe_d     = top_eff.pos;
              depth_d    = depth_q - DEPTH_W'(1);
              o_depth_d  = depth_q - DEPTH_W'(1);
              o_last_d   = (depth_q == DEPTH_W'(1));
              if (depth_q > DEPTH_W'(1)) begin
                ram_re  = 1'b1;
                state_d = S_DRAIN;
              end
            end
          end
        end
      end
      S_DRAIN: begin
        // depth_q counts the entry now on the RAM read port
        if (out_free) begin
          out_valid_d = 1'b1;
          o_idx_d     = drain_idx_q;
          o_kind_d    = NODE_NIL;
          o_match_d   = ram_rdata.idx;
          o_status_d  = {1'b0, ram_rdata.kind} + KIND_OFFSET;
          o_ps_d      = ram_rdata.pos;
          o_pe_d      = ram_rdata.pos;
          depth_d     = depth_q - DEPTH_W'(1);
          o_depth_d   = depth_q - DEPTH_W'(1);
          o_last_d    = (depth_q == DEPTH_W'(1));
          if (depth_q > DEPTH_W'(1)) begin
            ram_re = 1'b1;
          end else begin
            state_d = S_RUN;
          end
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      depth_q     <= '0;
      count_q     <= '0;
      fill_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      count_q     <= count_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q       <= top_d;
    drain_idx_q <= drain_idx_d;
    o_idx_q     <= o_idx_d;
    o_kind_q    <= o_kind_d;
    o_match_q   <= o_match_d;
    o_status_q  <= o_status_d;
    o_ps_q      <= o_ps_d;
    o_pe_q      <= o_pe_d;
    o_depth_q   <= o_depth_d;
    o_last_q    <= o_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign token_index_o   = o_idx_q;
  assign node_kind_o     = o_kind_q;
  assign match_index_o   = o_match_q;
  assign status_o        = o_status_q;
  assign err_pos_start_o = o_ps_q;
  assign err_pos_end_o   = o_pe_q;
  assign nest_depth_o    = o_depth_q;
  assign last_o          = o_last_q;

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth above capacity");

  a_fill_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q |-> depth_q != '0)
    else $error("top refill pending on an empty stack");

  a_drain_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> (in_stall_o && depth_q != '0))
    else $error("drain with input open or stack empty");

  a_dangle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o && status_o >= ST_DANGLE_LO && status_o <= ST_DANGLE_HI)
      |-> nest_depth_o == '0)
    else $error("final dangling report leaves entries on the stack");

  a_drain_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN && out_free) |=> depth_q == $past(depth_q) - DEPTH_W'(1))
    else $error("drain step did not pop");
`endif

endmodule

// ===== tb/tb_bracket_nesting_matcher_core.sv =====
// ----------------------------------------------------------------------------
// Bracket nesting matcher core testbench
// Drives classified token requests into the core and checks every result
// request against an in-bench model of the bracket stack. Covers plain tokens,
// all opener and closer kinds, mismatched closers, closers on an empty stack,
// stack overflow, end-marker drains and long output back-pressure, then
// random well-formed and broken bracket streams. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_bracket_nesting_matcher_core;
  import bnm_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 200;     // receiver hold-off under pressure
  localparam int SETTLE_CYCLES  = 80;      // a full drain is one result per cycle while the receiver does not stall
  localparam int RANDOM_TOKENS  = 330;
  localparam int TIMEOUT_CYCLES = 400_000;

  // token classes the package leaves out
  localparam logic [2:0] TOK_OPEN_PAR  = 3'd1;
  localparam logic [2:0] TOK_OPEN_BRK  = 3'd2;
  localparam logic [2:0] TOK_CLOSE_BRK = 3'd5;

  typedef struct packed {
    logic [INDEX_BITS-1:0] tok_idx;
    logic [2:0]            kind;
    logic [INDEX_BITS-1:0] match_idx;
    logic [2:0]            status;
    logic [POS_BITS-1:0]   pos_start;
    logic [POS_BITS-1:0]   pos_end;
    logic [DEPTH_W-1:0]    depth;
    logic                  last;
  } bracket_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [2:0]            token_class_i = TOK_OTHER;
  logic [POS_BITS-1:0]   token_pos_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [INDEX_BITS-1:0] token_index_o;
  logic [2:0]            node_kind_o;
  logic [INDEX_BITS-1:0] match_index_o;
  logic [2:0]            status_o;
  logic [POS_BITS-1:0]   err_pos_start_o;
  logic [POS_BITS-1:0]   err_pos_end_o;
  logic [DEPTH_W-1:0]    nest_depth_o;
  logic                  last_o;

  // model of the bracket stack, advanced when a token request is taken
  logic [1:0]            open_kind [STACK_DEPTH];
  logic [INDEX_BITS-1:0] open_idx  [STACK_DEPTH];
  logic [POS_BITS-1:0]   open_pos  [STACK_DEPTH];
  int                    open_depth = 0;
  logic [INDEX_BITS-1:0] next_index = '0;
  bracket_result_t       awaited_results[$];

  int   fail_count   = 0;
  int   tokens_sent  = 0;
  int   burst_tokens = 0;
  bit   no_gaps      = 1'b0;

  // receiver side: long hold-off request and stall pacing
  logic long_hold    = 1'b0;
  bit   hold_armed   = 1'b0;
  int   hold_left    = 0;
  int   stall_run    = 0;

  bracket_nesting_matcher_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .token_class_i  (token_class_i),
    .token_pos_i    (token_pos_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_index_o  (token_index_o),
    .node_kind_o    (node_kind_o),
    .match_index_o  (match_index_o),
    .status_o       (status_o),
    .err_pos_start_o(err_pos_start_o),
    .err_pos_end_o  (err_pos_end_o),
    .nest_depth_o   (nest_depth_o),
    .last_o         (last_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Stack model: works out the results one token causes
  // --------------------------------------------------------------------------
  function automatic void match_brackets(input logic [2:0] cls,
                                         input logic [POS_BITS-1:0] pos);
    bracket_result_t r;
    logic [1:0]      want;
    r = '0;
    r.tok_idx = next_index;
    r.last = 1'b1;
    next_index = next_index + INDEX_BITS'(1);
    if (cls == TOK_OTHER) begin
      r.kind = NODE_PLAIN;
      r.depth = DEPTH_W'(open_depth);
      awaited_results.push_back(r);
    end else if (cls < TOK_CLOSE_PAR) begin
      r.kind = cls;
      if (open_depth < STACK_DEPTH) begin
        open_kind[open_depth] = cls[1:0];
        open_idx[open_depth]  = r.tok_idx;
        open_pos[open_depth]  = pos;
        open_depth++;
      end else begin
        // full stack: opener dropped, its own position marks the span
        r.status = ST_OVERFLOW;
        r.pos_start = pos;
        r.pos_end = pos;
      end
      r.depth = DEPTH_W'(open_depth);
      awaited_results.push_back(r);
    end else if (cls < TOK_END) begin
      want = 2'(cls - KIND_OFFSET);
      r.kind = NODE_NIL;
      if (open_depth > 0 && open_kind[open_depth-1] == want) begin
        open_depth--;
        r.match_idx = open_idx[open_depth];
      end else begin
        // mismatch or empty stack: stack untouched, span from top opener
        r.status = cls - KIND_OFFSET;
        r.pos_end = pos;
        if (open_depth > 0) r.pos_start = open_pos[open_depth-1];
      end
      r.depth = DEPTH_W'(open_depth);
      awaited_results.push_back(r);
    end else begin
      // end marker: all results carry its index; dangling openers top first
      r.kind = NODE_NIL;
      if (open_depth == 0) begin
        awaited_results.push_back(r);
      end
      while (open_depth > 0) begin
        open_depth--;
        r.match_idx = open_idx[open_depth];
        r.status = {1'b0, open_kind[open_depth]} + KIND_OFFSET;
        r.pos_start = open_pos[open_depth];
        r.pos_end = open_pos[open_depth];
        r.depth = DEPTH_W'(open_depth);
        r.last = (open_depth == 0);
        awaited_results.push_back(r);
      end
      next_index = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    if (burst_tokens > 0) begin
      burst_tokens--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_tokens = $urandom_range(20, 50);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [POS_BITS-1:0] random_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom();
  endfunction

  // valid is only lowered when a gap follows, so a back-to-back request
  // never sees two assignments to valid in one step
  task automatic send_token(input logic [2:0] cls, input logic [POS_BITS-1:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    token_class_i <= cls;
    token_pos_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
    match_brackets(cls, pos);
    tokens_sent++;
  endtask

  // one run of tokens, pushing up to cap deep apart from noise and mostly closing correctly
  task automatic send_bracket_run(input int cap, input int push_pct, input int length);
    int         r;
    logic [2:0] cls;
    for (int n = 0; n < length; n++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        cls = TOK_OTHER;
      end else if (r < 95) begin
        if (open_depth == 0 ||
            (open_depth < cap && $urandom_range(0, 99) < push_pct)) begin
          cls = 3'($urandom_range(1, 3));
        end else if ($urandom_range(0, 99) < 90) begin
          cls = {1'b0, open_kind[open_depth-1]} + KIND_OFFSET;
        end else begin
          cls = 3'($urandom_range(4, 6));
        end
      end else begin
        // noise: any class but the end marker, may overflow or hit empty
        cls = 3'($urandom_range(0, 6));
      end
      send_token(cls, random_pos());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_tokens();
    send_token(TOK_END,       32'h0000_0000);   // end on empty stack
    send_token(TOK_OTHER,     32'hFFFF_FFFF);
    send_token(TOK_CLOSE_PAR, 32'h1234_5678);   // closers on empty stack
    send_token(TOK_CLOSE_BRK, 32'hFFFF_FFFF);
    send_token(TOK_CLOSE_BRC, 32'h0000_0000);
    send_token(TOK_OPEN_PAR,  32'hFFFF_FFFF);
    send_token(TOK_OPEN_BRK,  32'h0000_0000);
    send_token(TOK_OPEN_BRC,  32'hA5A5_A5A5);
    send_token(TOK_CLOSE_PAR, 32'h5A5A_5A5A);   // mismatch against brace
    send_token(TOK_CLOSE_BRC, 32'h0000_0001);
    send_token(TOK_CLOSE_PAR, 32'h8000_0000);   // mismatch against bracket
    send_token(TOK_CLOSE_BRK, 32'h7FFF_FFFF);
    send_token(TOK_CLOSE_PAR, 32'h0000_0002);
    send_token(TOK_OPEN_BRC,  32'hDEAD_0001);
    send_token(TOK_OPEN_PAR,  32'hDEAD_0002);
    send_token(TOK_OPEN_BRK,  32'hDEAD_0003);
    send_token(TOK_OTHER,     32'h0000_0000);
    send_token(TOK_END,       32'hFFFF_FFFF);   // three dangling openers
    send_token(TOK_OPEN_PAR,  32'h0F0F_0F0F);
    send_token(TOK_END,       32'h0000_0003);   // single dangling opener
  endtask

  task automatic test_stack_overflow();
    logic [1:0] top;
    while (open_depth < STACK_DEPTH) send_token(3'($urandom_range(1, 3)), $urandom());
    send_token(TOK_OPEN_PAR, random_pos());
    send_token(TOK_OPEN_BRK, random_pos());
    send_token(TOK_OPEN_BRC, random_pos());
    top = open_kind[open_depth-1];
    send_token(3'((top % 3) + 1) + KIND_OFFSET, random_pos());   // mismatch on full
    send_token({1'b0, top} + KIND_OFFSET, random_pos());         // pop one
    send_token(TOK_OPEN_BRK, random_pos());                      // full again
    send_token(TOK_OPEN_PAR, random_pos());                      // overflow
    send_token(TOK_END, random_pos());                           // drain full stack
  endtask

  // receiver stops for a long stretch while tokens keep coming, so the
  // core backs up and must stall its input
  task automatic test_output_backpressure();
    long_hold <= 1'b1;
    no_gaps = 1'b1;
    send_bracket_run(12, 60, 40);
    send_token(TOK_END, random_pos());
    no_gaps = 1'b0;
    long_hold <= 1'b0;
  endtask

  task automatic test_random_streams();
    int target;
    target = tokens_sent + RANDOM_TOKENS;
    while (tokens_sent < target) begin
      if ($urandom_range(0, 5) == 0) begin
        send_bracket_run(STACK_DEPTH, 75, $urandom_range(80, 140));
      end else begin
        send_bracket_run($urandom_range(1, 8), 50, $urandom_range(3, 30));
      end
      // most streams close with an end marker, the rest run into the next
      if ($urandom_range(0, 99) < 85) send_token(TOK_END, random_pos());
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_tokens();
    test_stack_overflow();
    test_output_backpressure();
    test_random_streams();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("bracket_nesting_matcher_core verification clean");
    end else begin
      $display("bracket_nesting_matcher_core verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("bracket_nesting_matcher_core verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pacing, with the long hold-off counted here
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : stall_driver
    int r;
    if (long_hold && !hold_armed) hold_left = HOLD_CYCLES;
    hold_armed = long_hold;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall_i <= 1'b0;
        stall_run = $urandom_range(0, 4);
      end else if (r < 80) begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else if (r < 88) begin
        out_stall_i <= 1'b1;
        stall_run = $urandom_range(8, 30);
      end else begin
        out_stall_i <= 1'b0;
        stall_run = $urandom_range(30, 80);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // results are taken at edges where valid is high and stall is low
  always @(posedge clk_i) begin : result_check
    bracket_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual index %0h status %0d",
                 $time, token_index_o, status_o);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("token_index",   32'(want.tok_idx),   32'(token_index_o));
        check_field("node_kind",     32'(want.kind),      32'(node_kind_o));
        check_field("match_index",   32'(want.match_idx), 32'(match_index_o));
        check_field("status",        32'(want.status),    32'(status_o));
        check_field("err_pos_start", want.pos_start,      err_pos_start_o);
        check_field("err_pos_end",   want.pos_end,        err_pos_end_o);
        check_field("nest_depth",    32'(want.depth),     32'(nest_depth_o));
        check_field("last",          32'(want.last),      32'(last_o));
      end
    end
  end

endmodule

// ===== filelist.f =====
src/bnm_pkg.sv
src/bnm_ram.sv
src/bracket_nesting_matcher_core.sv
tb/tb_bracket_nesting_matcher_core.sv
